// ===== design/vsau_pkg.sv =====
// vsau_pkg: shared types and constants for the video scroll address unit
// holds the event codes, the scroll state record and the result record
// no dependencies
package vsau_pkg;

  typedef enum logic [3:0] {
    MODE_CTRL   = 4'd0,
    MODE_SCROLL = 4'd1,
    MODE_ADDR   = 4'd2,
    MODE_STATUS = 4'd3,
    MODE_DATA   = 4'd4,
    MODE_INCX   = 4'd5,
    MODE_INCY   = 4'd6,
    MODE_COPYH  = 4'd7,
    MODE_COPYV  = 4'd8
  } vsau_mode_t;

  localparam logic [13:0] NT_BASE     = 14'h2000;
  localparam logic [13:0] ATTR_BASE   = 14'h23c0;
  localparam logic [14:0] STEP_ROW    = 15'd32;
  localparam logic [14:0] STEP_COL    = 15'd1;
  localparam logic [4:0]  COARSE_LAST = 5'd31;
  localparam logic [4:0]  ROW_LAST    = 5'd29;
  localparam logic [2:0]  FINE_LAST   = 3'd7;
  localparam logic [13:0] PLANE_HIGH  = 14'd8;

  // scroll registers: fine y 14:12, nametable 11:10, coarse y 9:5, coarse x 4:0
  typedef struct packed {
    logic [14:0] cur_addr;
    logic [14:0] tmp_addr;
    logic [2:0]  fine_x;
    logic        second_write;
    logic        step_by_row;
    logic        bg_table_high;
  } vsau_state_t;

  typedef struct packed {
    logic [13:0] access_address;
    logic [14:0] current_address;
    logic [13:0] nametable_address;
    logic [13:0] attribute_address;
    logic [12:0] pattern_low_address;
    logic [13:0] pattern_high_address;
    logic [2:0]  fine_x_out;
    logic        toggle_out;
  } vsau_result_t;

endpackage

// ===== design/vsau_step.sv =====
// vsau_step: next-state and fetch address logic for one event
// depends on vsau_pkg for the event codes, state and result records
module vsau_step import vsau_pkg::*; (
  input  logic [3:0]   mode,
  input  logic [7:0]   data_byte,
  input  logic [7:0]   tile_number,
  input  vsau_state_t  st,
  output vsau_state_t  st_nxt,
  output vsau_result_t res
);

  vsau_mode_t  mode_e;
  logic [14:0] y_next;
  logic [4:0]  row_cnt;
  logic [14:0] addr_full;
  logic [12:0] plo;

  assign mode_e    = vsau_mode_t'(mode);
  assign addr_full = {st.tmp_addr[14:8], data_byte};

  // vertical increment with nametable wrap at row 29
  always_comb begin
    y_next  = st.cur_addr;
    row_cnt = st.cur_addr[9:5];
    if (st.cur_addr[14:12] != FINE_LAST) begin
      y_next[14:12] = st.cur_addr[14:12] + 3'd1;
    end else begin
      y_next[14:12] = 3'd0;
      if (row_cnt == ROW_LAST) begin
        y_next[9:5] = 5'd0;
        y_next[11]  = ~st.cur_addr[11];
      end else if (row_cnt == COARSE_LAST) begin
        y_next[9:5] = 5'd0;
      end else begin
        y_next[9:5] = row_cnt + 5'd1;
      end
    end
  end

  always_comb begin
    st_nxt = st;
    unique case (mode_e)
      MODE_CTRL: begin
        st_nxt.tmp_addr[11:10] = data_byte[1:0];
        st_nxt.step_by_row     = data_byte[2];
        st_nxt.bg_table_high   = data_byte[4];
      end
      MODE_SCROLL: begin
        if (st.second_write) begin
          st_nxt.tmp_addr[14:12] = data_byte[2:0];
          st_nxt.tmp_addr[9:5]   = data_byte[7:3];
          st_nxt.second_write    = 1'b0;
        end else begin
          st_nxt.tmp_addr[4:0] = data_byte[7:3];
          st_nxt.fine_x        = data_byte[2:0];
          st_nxt.second_write  = 1'b1;
        end
      end
      MODE_ADDR: begin
        if (st.second_write) begin
          st_nxt.tmp_addr     = addr_full;
          st_nxt.cur_addr     = addr_full;
          st_nxt.second_write = 1'b0;
        end else begin
          st_nxt.tmp_addr[14:8] = {1'b0, data_byte[5:0]};
          st_nxt.second_write   = 1'b1;
        end
      end
      MODE_STATUS: begin
        st_nxt.second_write = 1'b0;
      end
      MODE_DATA: begin
        st_nxt.cur_addr = st.cur_addr + (st.step_by_row ? STEP_ROW : STEP_COL);
      end
      MODE_INCX: begin
        if (st.cur_addr[4:0] == COARSE_LAST) begin
          st_nxt.cur_addr[4:0] = 5'd0;
          st_nxt.cur_addr[10]  = ~st.cur_addr[10];
        end else begin
          st_nxt.cur_addr[4:0] = st.cur_addr[4:0] + 5'd1;
        end
      end
      MODE_INCY: begin
        st_nxt.cur_addr = y_next;
      end
      MODE_COPYH: begin
        st_nxt.cur_addr[10]  = st.tmp_addr[10];
        st_nxt.cur_addr[4:0] = st.tmp_addr[4:0];
      end
      MODE_COPYV: begin
        st_nxt.cur_addr[14:11] = st.tmp_addr[14:11];
        st_nxt.cur_addr[9:5]   = st.tmp_addr[9:5];
      end
      default: begin
      end
    endcase
  end

  // table select, tile and fine y occupy disjoint bits of the pattern address
  assign plo = {st_nxt.bg_table_high, tile_number, 1'b0, st_nxt.cur_addr[14:12]};

  always_comb begin
    res.access_address       = st.cur_addr[13:0];
    res.current_address      = st_nxt.cur_addr;
    res.nametable_address    = NT_BASE | {2'b00, st_nxt.cur_addr[11:0]};
    res.attribute_address    = ATTR_BASE | {2'b00, st_nxt.cur_addr[11:10], 4'd0,
                               st_nxt.cur_addr[9:7], st_nxt.cur_addr[4:2]};
    res.pattern_low_address  = plo;
    res.pattern_high_address = {1'b0, plo} + PLANE_HIGH;
    res.fine_x_out           = st_nxt.fine_x;
    res.toggle_out           = st_nxt.second_write;
  end

endmodule

// ===== design/video_scroll_address_unit.sv =====
// video_scroll_address_unit: scroll and address registers with fetch address outputs
// an accepted event's result reaches the output register in the next cycle; throughput is
// one event per cycle while in_stall is low, set by the single update path of the scroll
// registers; the output register is refilled in the cycle it is taken, so input stalls only
// while a result waits and out_stall is high; rst_n is synchronous, clears all but res_r
module video_scroll_address_unit import vsau_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  in_mode,
  input  logic [7:0]  in_data_byte,
  input  logic [7:0]  in_tile_number,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [13:0] out_access_address,
  output logic [14:0] out_current_address,
  output logic [13:0] out_nametable_address,
  output logic [13:0] out_attribute_address,
  output logic [12:0] out_pattern_low_address,
  output logic [13:0] out_pattern_high_address,
  output logic [2:0]  out_fine_x_out,
  output logic        out_toggle_out
);

  vsau_state_t  state_r;
  vsau_state_t  state_nxt;
  vsau_result_t res_r;
  vsau_result_t res_nxt;
  logic         out_valid_r;
  logic         in_fire;

  vsau_step u_step (
    .mode        (in_mode),
    .data_byte   (in_data_byte),
    .tile_number (in_tile_number),
    .st          (state_r),
    .st_nxt      (state_nxt),
    .res         (res_nxt)
  );

  assign in_stall = out_valid_r & out_stall;
  assign in_fire  = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        state_r <= state_nxt;
      end
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload, loaded with each accepted item
  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid                = out_valid_r;
  assign out_access_address       = res_r.access_address;
  assign out_current_address      = res_r.current_address;
  assign out_nametable_address    = res_r.nametable_address;
  assign out_attribute_address    = res_r.attribute_address;
  assign out_pattern_low_address  = res_r.pattern_low_address;
  assign out_pattern_high_address = res_r.pattern_high_address;
  assign out_fine_x_out           = res_r.fine_x_out;
  assign out_toggle_out           = res_r.toggle_out;

`ifndef ASSERT_OFF
  a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid)
    else $error("accepted item produced no result");

  a_drain_empties: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !in_fire |=> !out_valid)
    else $error("taken result was repeated");

  a_result_tracks_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_current_address == state_r.cur_addr
                  && out_fine_x_out == state_r.fine_x
                  && out_toggle_out == state_r.second_write)
    else $error("result does not match scroll registers");

  a_nametable_window: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_nametable_address[13:12] == 2'b10)
    else $error("nametable address outside its window");
`endif

endmodule
